// ===== sv/cap_pkg.sv =====
package cap_pkg;

  localparam int IN_CW          = 10;
  localparam int IN_RW          = 6;
  localparam int BEAR_W         = 2;
  localparam int PT_W           = 12;
  localparam int RAD_CAP        = (2 ** IN_RW) - 1;
  localparam int STEP_CAP       = 46;
  localparam int STEP_W         = $clog2(STEP_CAP);
  localparam int QUEUE_DEPTH    = 2;
  localparam int MAX_RADIUS_DEF = 63;
  localparam int COORD_BITS_DEF = 10;

  typedef enum logic [BEAR_W-1:0] {
    BEAR_NORTH,
    BEAR_EAST,
    BEAR_SOUTH,
    BEAR_WEST
  } bearing_t;

  typedef enum logic {
    WALK_IDLE,
    WALK_RUN
  } walk_state_t;

  function automatic int coord_w(int cb);
    return (cb < IN_CW) ? cb : IN_CW;
  endfunction

  function automatic int rad_max(int mr);
    return (mr < RAD_CAP) ? mr : RAD_CAP;
  endfunction

  function automatic int rad_w(int mr);
    return $clog2(rad_max(mr) + 1);
  endfunction

  function automatic int cmd_w(int mr, int cb);
    return 2 * coord_w(cb) + rad_w(mr) + BEAR_W;
  endfunction

endpackage

// ===== sv/cap_front.sv =====
module cap_front #(
  parameter int MAX_RADIUS = cap_pkg::MAX_RADIUS_DEF,
  parameter int COORD_BITS = cap_pkg::COORD_BITS_DEF
) (
  input  logic                                                 in_valid,
  output logic                                                 in_stall,
  input  logic [cap_pkg::IN_CW-1:0]                            center_x,
  input  logic [cap_pkg::IN_CW-1:0]                            center_y,
  input  logic [cap_pkg::IN_RW-1:0]                            radius,
  input  logic [cap_pkg::BEAR_W-1:0]                           bearing,
  output logic                                                 push_valid,
  input  logic                                                 push_stall,
  output logic [cap_pkg::cmd_w(MAX_RADIUS, COORD_BITS)-1:0]    push_data
);
  import cap_pkg::*;

  localparam int CW = coord_w(COORD_BITS);
  localparam int RW = rad_w(MAX_RADIUS);
  localparam logic [IN_RW-1:0] RMAX_V = IN_RW'(rad_max(MAX_RADIUS));

  logic [IN_RW-1:0] r_clamped;

  // clamp radius, wrap center into the coordinate range
  always_comb begin
    r_clamped  = (radius > RMAX_V) ? RMAX_V : radius;
    push_data  = {bearing, r_clamped[RW-1:0], center_y[CW-1:0], center_x[CW-1:0]};
    push_valid = in_valid;
    in_stall   = push_stall;
  end

endmodule

// ===== sv/cap_queue.sv =====
module cap_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_stall,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_stall,
  output logic [W-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic [NW-1:0] count_next;
  logic          push;
  logic          pop;

  assign push_stall = (count == NW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + NW'(1);
      2'b01:   count_next = count - NW'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/cap_back.sv =====
module cap_back #(
  parameter int MAX_RADIUS = cap_pkg::MAX_RADIUS_DEF,
  parameter int COORD_BITS = cap_pkg::COORD_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              pop_valid,
  output logic                                              pop_stall,
  input  logic [cap_pkg::cmd_w(MAX_RADIUS, COORD_BITS)-1:0] pop_data,
  output logic                                              out_valid,
  input  logic                                              out_stall,
  output logic signed [cap_pkg::PT_W-1:0]                   p0_x,
  output logic signed [cap_pkg::PT_W-1:0]                   p0_y,
  output logic signed [cap_pkg::PT_W-1:0]                   p1_x,
  output logic signed [cap_pkg::PT_W-1:0]                   p1_y,
  output logic signed [cap_pkg::PT_W-1:0]                   p2_x,
  output logic signed [cap_pkg::PT_W-1:0]                   p2_y,
  output logic signed [cap_pkg::PT_W-1:0]                   p3_x,
  output logic signed [cap_pkg::PT_W-1:0]                   p3_y,
  output logic                                              last
);
  import cap_pkg::*;

  localparam int CW = coord_w(COORD_BITS);
  localparam int RW = rad_w(MAX_RADIUS);
  localparam int XW = RW + 2;
  localparam int DW = RW + 5;
  localparam int EW = DW + 2;

  walk_state_t             state;
  walk_state_t             state_next;
  logic [CW-1:0]           ax;
  logic [CW-1:0]           by;
  bearing_t                bear;
  logic signed [XW-1:0]    x;
  logic signed [XW-1:0]    y;
  logic signed [XW-1:0]    x_next;
  logic signed [XW-1:0]    y_next;
  logic signed [XW-1:0]    x_inc;
  logic signed [XW-1:0]    y_dec;
  logic signed [DW-1:0]    delta;
  logic signed [DW-1:0]    delta_next;
  logic signed [DW-1:0]    delta_init;
  logic signed [DW-1:0]    r_ext;
  logic signed [EW-1:0]    err;
  logic [STEP_W-1:0]       step;
  logic                    done;
  logic                    emit;
  logic                    load;
  logic                    out_valid_next;
  logic [CW-1:0]           cmd_cx;
  logic [CW-1:0]           cmd_cy;
  logic [RW-1:0]           cmd_r;
  bearing_t                cmd_b;
  logic signed [PT_W-1:0]  ae;
  logic signed [PT_W-1:0]  be;
  logic signed [PT_W-1:0]  xe;
  logic signed [PT_W-1:0]  ye;
  logic signed [PT_W-1:0]  pt [8];

  always_comb begin
    cmd_cx     = pop_data[CW-1:0];
    cmd_cy     = pop_data[2*CW-1:CW];
    cmd_r      = pop_data[2*CW+RW-1:2*CW];
    cmd_b      = bearing_t'(pop_data[2*CW+RW+BEAR_W-1:2*CW+RW]);
    r_ext      = DW'($signed({1'b0, cmd_r}));
    delta_init = DW'(1) - (r_ext <<< 1);
  end

  // one walk step
  always_comb begin
    err   = ((EW'(delta) + EW'(y)) <<< 1) - EW'(1);
    x_inc = x + XW'(1);
    y_dec = y - XW'(1);
    priority if (delta < 0 && err <= 0) begin
      x_next     = x_inc;
      y_next     = y;
      delta_next = delta + (DW'(x_inc) <<< 1) + DW'(1);
    end else if (delta > 0 && err > 0) begin
      x_next     = x;
      y_next     = y_dec;
      delta_next = delta - (DW'(y_dec) <<< 1) - DW'(1);
    end else begin
      x_next     = x_inc;
      y_next     = y_dec;
      delta_next = delta + (DW'(x_inc - y_dec) <<< 1);
    end
    done = (y_next < x_next) || (step == STEP_W'(STEP_CAP - 1));
  end

  // mirror the current point into the chosen half-plane
  always_comb begin
    ae = PT_W'({1'b0, ax});
    be = PT_W'({1'b0, by});
    xe = PT_W'(x);
    ye = PT_W'(y);
    unique case (bear)
      BEAR_NORTH: begin
        pt[0] = ae + xe; pt[1] = be + ye;
        pt[2] = ae - xe; pt[3] = be + ye;
        pt[4] = ae + ye; pt[5] = be + xe;
        pt[6] = ae - ye; pt[7] = be + xe;
      end
      BEAR_EAST: begin
        pt[0] = ae + xe; pt[1] = be + ye;
        pt[2] = ae + xe; pt[3] = be - ye;
        pt[4] = ae + ye; pt[5] = be + xe;
        pt[6] = ae + ye; pt[7] = be - xe;
      end
      BEAR_SOUTH: begin
        pt[0] = ae + xe; pt[1] = be - ye;
        pt[2] = ae - xe; pt[3] = be - ye;
        pt[4] = ae + ye; pt[5] = be - xe;
        pt[6] = ae - ye; pt[7] = be - xe;
      end
      BEAR_WEST: begin
        pt[0] = ae - xe; pt[1] = be + ye;
        pt[2] = ae - xe; pt[3] = be - ye;
        pt[4] = ae - ye; pt[5] = be + xe;
        pt[6] = ae - ye; pt[7] = be - xe;
      end
      default: begin
        pt[0] = ae; pt[1] = be;
        pt[2] = ae; pt[3] = be;
        pt[4] = ae; pt[5] = be;
        pt[6] = ae; pt[7] = be;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    pop_stall  = 1'b1;
    load       = 1'b0;
    emit       = 1'b0;
    unique case (state)
      WALK_IDLE: begin
        pop_stall = 1'b0;
        if (pop_valid) begin
          load       = 1'b1;
          state_next = WALK_RUN;
        end
      end
      WALK_RUN: begin
        if (!out_valid || !out_stall) begin
          emit = 1'b1;
          if (done) begin
            state_next = WALK_IDLE;
          end
        end
      end
      default: state_next = WALK_IDLE;
    endcase
    out_valid_next = emit || (out_valid && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= WALK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ax    <= cmd_cx;
      by    <= cmd_cy;
      bear  <= cmd_b;
      x     <= '0;
      y     <= XW'($signed({1'b0, cmd_r}));
      delta <= delta_init;
      step  <= '0;
    end else if (emit) begin
      x     <= x_next;
      y     <= y_next;
      delta <= delta_next;
      step  <= step + STEP_W'(1);
    end
    if (emit) begin
      p0_x <= pt[0];
      p0_y <= pt[1];
      p1_x <= pt[2];
      p1_y <= pt[3];
      p2_x <= pt[4];
      p2_y <= pt[5];
      p3_x <= pt[6];
      p3_y <= pt[7];
      last <= done;
    end
  end

  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    (state == WALK_RUN) |-> (y >= x))
    else $error("walk running past the octant end");

  a_load_start: assert property (@(posedge clk) disable iff (rst)
    (state == WALK_IDLE && pop_valid) |=> (state == WALK_RUN && step == '0 && x == '0))
    else $error("walk did not start from a fresh command");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && done) |=> (state == WALK_IDLE && out_valid && last))
    else $error("final step not flagged or walk not stopped");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == WALK_RUN) |-> (step < STEP_W'(STEP_CAP)))
    else $error("step count beyond cap");

endmodule

// ===== sv/circle_arc_point_generator.sv =====
// Arc point generator: one command in, a burst of point results out.
// Input channel: in_valid/in_stall with center_x, center_y, radius and
// bearing. A command transfers when in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall with four mirrored points per walk
// step and last set on the final step of each arc.
// The front part clamps the radius and wraps the center, then pushes the
// command into a two-entry queue; the back part pops one command at a time
// and runs the circle walk.
// The first result of a command passes the queue entry, the walk registers
// and the output registers, when the back part is free.
// Throughput: one result per cycle while the receiver takes them; a radius
// R arc gives about R/sqrt(2)+1 results (46 for R=63), plus a load step for
// the next command. The walk register loop in the back part sets it.
// Reset clears the queue, the walk state and out_valid.
// While out_stall is high the held result stays put, the walk pauses, and
// the queue keeps taking commands until it is full.
module circle_arc_point_generator #(
  parameter int MAX_RADIUS = cap_pkg::MAX_RADIUS_DEF,
  parameter int COORD_BITS = cap_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [cap_pkg::IN_CW-1:0]       center_x,
  input  logic [cap_pkg::IN_CW-1:0]       center_y,
  input  logic [cap_pkg::IN_RW-1:0]       radius,
  input  logic [cap_pkg::BEAR_W-1:0]      bearing,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [cap_pkg::PT_W-1:0] p0_x,
  output logic signed [cap_pkg::PT_W-1:0] p0_y,
  output logic signed [cap_pkg::PT_W-1:0] p1_x,
  output logic signed [cap_pkg::PT_W-1:0] p1_y,
  output logic signed [cap_pkg::PT_W-1:0] p2_x,
  output logic signed [cap_pkg::PT_W-1:0] p2_y,
  output logic signed [cap_pkg::PT_W-1:0] p3_x,
  output logic signed [cap_pkg::PT_W-1:0] p3_y,
  output logic                            last
);
  import cap_pkg::*;

  localparam int CMD_W = cmd_w(MAX_RADIUS, COORD_BITS);

  logic             push_valid;
  logic             push_stall;
  logic [CMD_W-1:0] push_data;
  logic             pop_valid;
  logic             pop_stall;
  logic [CMD_W-1:0] pop_data;

  cap_front #(
    .MAX_RADIUS (MAX_RADIUS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .center_x   (center_x),
    .center_y   (center_y),
    .radius     (radius),
    .bearing    (bearing),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_data  (push_data)
  );

  cap_queue #(
    .W     (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_stall  (pop_stall),
    .pop_data   (pop_data)
  );

  cap_back #(
    .MAX_RADIUS (MAX_RADIUS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_stall (pop_stall),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .p0_x      (p0_x),
    .p0_y      (p0_y),
    .p1_x      (p1_x),
    .p1_y      (p1_y),
    .p2_x      (p2_x),
    .p2_y      (p2_y),
    .p3_x      (p3_x),
    .p3_y      (p3_y),
    .last      (last)
  );

endmodule

// ===== tb/sv/circle_arc_point_generator_checker.sv =====
`timescale 1ns / 100ps
module circle_arc_point_generator_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [cap_pkg::IN_CW-1:0]        center_x,
  input  logic [cap_pkg::IN_CW-1:0]        center_y,
  input  logic [cap_pkg::IN_RW-1:0]        radius,
  input  logic [cap_pkg::BEAR_W-1:0]       bearing,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic signed [cap_pkg::PT_W-1:0]  p0_x,
  input  logic signed [cap_pkg::PT_W-1:0]  p0_y,
  input  logic signed [cap_pkg::PT_W-1:0]  p1_x,
  input  logic signed [cap_pkg::PT_W-1:0]  p1_y,
  input  logic signed [cap_pkg::PT_W-1:0]  p2_x,
  input  logic signed [cap_pkg::PT_W-1:0]  p2_y,
  input  logic signed [cap_pkg::PT_W-1:0]  p3_x,
  input  logic signed [cap_pkg::PT_W-1:0]  p3_y,
  input  logic                             last,
  output int                               fail_count,
  output int                               pending,
  output int                               arcs_seen,
  output int                               steps_seen
);
  import cap_pkg::*;

  typedef struct packed {
    logic [3:0][PT_W-1:0] px;
    logic [3:0][PT_W-1:0] py;
    logic                 last;
  } arc_step_t;

  arc_step_t step_q[$];
  arc_step_t want;
  arc_step_t got;

  task automatic plan_arc(input int a, input int b, input int rad, input bearing_t bear);
    int x, y, d, e, cx, cy, n;
    int px[4];
    int py[4];
    arc_step_t s;
    if (rad > MAX_RADIUS_DEF) rad = MAX_RADIUS_DEF;
    x = 0;
    y = rad;
    d = 1 - 2 * rad;
    n = 0;
    while (y >= x && n < STEP_CAP) begin
      cx = x;
      cy = y;
      e = 2 * (d + y) - 1;
      if (d < 0 && e <= 0) begin
        x = x + 1;
        d = d + 2 * x + 1;
      end else if (d > 0 && e > 0) begin
        y = y - 1;
        d = d - (2 * y + 1);
      end else begin
        x = x + 1;
        y = y - 1;
        d = d + 2 * (x - y);
      end
      case (bear)
        BEAR_NORTH: begin
          px = '{a + cx, a - cx, a + cy, a - cy};
          py = '{b + cy, b + cy, b + cx, b + cx};
        end
        BEAR_EAST: begin
          px = '{a + cx, a + cx, a + cy, a + cy};
          py = '{b + cy, b - cy, b + cx, b - cx};
        end
        BEAR_SOUTH: begin
          px = '{a + cx, a - cx, a + cy, a - cy};
          py = '{b - cy, b - cy, b - cx, b - cx};
        end
        default: begin
          px = '{a - cx, a - cx, a - cy, a - cy};
          py = '{b + cy, b - cy, b + cx, b - cx};
        end
      endcase
      for (int k = 0; k < 4; k++) begin
        s.px[k] = PT_W'(px[k]);
        s.py[k] = PT_W'(py[k]);
      end
      s.last = (y < x) || (n + 1 >= STEP_CAP);
      step_q.push_back(s);
      n++;
    end
  endtask

  task automatic check_field(input string name, input logic [PT_W-1:0] exp_v,
                             input logic [PT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      step_q.delete();
      fail_count = 0;
      pending = 0;
      arcs_seen = 0;
      steps_seen = 0;
    end else begin
      if (in_valid && !in_stall) begin
        plan_arc(int'(center_x), int'(center_y), int'(radius), bearing_t'(bearing));
        arcs_seen++;
      end
      if (out_valid && !out_stall) begin
        steps_seen++;
        if (step_q.size() == 0) begin
          $error("point transfer with no arc step pending");
          fail_count++;
        end else begin
          want = step_q.pop_front();
          got.px = {p3_x, p2_x, p1_x, p0_x};
          got.py = {p3_y, p2_y, p1_y, p0_y};
          got.last = last;
          for (int k = 0; k < 4; k++) begin
            check_field($sformatf("p%0d_x", k), want.px[k], got.px[k]);
            check_field($sformatf("p%0d_y", k), want.py[k], got.py[k]);
          end
          check_field("last", PT_W'(want.last), PT_W'(got.last));
        end
      end
      pending = step_q.size();
    end
  end

endmodule

// ===== tb/sv/circle_arc_point_generator_test.sv =====
`timescale 1ns / 100ps
module circle_arc_point_generator_test;
  import cap_pkg::*;

  localparam int RANDOM_ARCS  = 450;
  localparam int LONG_HOLD    = 400;
  localparam int FLOOD_START  = 40;
  localparam int FLOOD_END    = 70;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DRAIN_CYCLES = 20;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [IN_CW-1:0]       center_x = '0;
  logic [IN_CW-1:0]       center_y = '0;
  logic [IN_RW-1:0]       radius = '0;
  logic [BEAR_W-1:0]      bearing = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [PT_W-1:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
  logic                   last;

  int fail_count, pending, arcs_seen, steps_seen;
  int sent = 0;
  int cycles = 0;
  bit long_hold_done = 1'b0;

  circle_arc_point_generator dut (.*);
  circle_arc_point_generator_checker chk (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int idle_cycles(input int idx);
    int r;
    r = $urandom_range(0, 99);
    if ((sent >= FLOOD_START && sent < FLOOD_END) || (idx % 100) < 12) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_arc(input logic [IN_CW-1:0] cx, input logic [IN_CW-1:0] cy,
                          input logic [IN_RW-1:0] rad, input bearing_t bear,
                          input int gap);
    center_x = cx;
    center_y = cy;
    radius = rad;
    bearing = bear;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin
    int r, len;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!long_hold_done && sent >= FLOOD_START) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall = 1'b0;
          len = $urandom_range(1, 8);
        end else if (r < 88) begin
          out_stall = 1'b1;
          len = $urandom_range(1, 3);
        end else if (r < 95) begin
          out_stall = 1'b1;
          len = $urandom_range(10, 40);
        end else begin
          out_stall = 1'b0;
          len = $urandom_range(20, 60);
        end
        repeat (len) @(negedge clk);
      end
    end
  end

  initial begin
    logic [IN_RW-1:0] rad;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_arc(10'd0, 10'd0, 6'd0, BEAR_NORTH, idle_cycles(0));
    send_arc(10'd1023, 10'd1023, 6'd0, BEAR_WEST, idle_cycles(1));
    send_arc(10'd0, 10'd0, 6'd63, BEAR_NORTH, idle_cycles(2));
    send_arc(10'd0, 10'd0, 6'd63, BEAR_EAST, idle_cycles(3));
    send_arc(10'd0, 10'd0, 6'd63, BEAR_SOUTH, idle_cycles(4));
    send_arc(10'd0, 10'd0, 6'd63, BEAR_WEST, idle_cycles(5));
    send_arc(10'd1023, 10'd1023, 6'd63, BEAR_NORTH, idle_cycles(6));
    send_arc(10'd1023, 10'd1023, 6'd63, BEAR_EAST, idle_cycles(7));
    send_arc(10'd1023, 10'd1023, 6'd63, BEAR_SOUTH, idle_cycles(8));
    send_arc(10'd1023, 10'd1023, 6'd63, BEAR_WEST, idle_cycles(9));
    send_arc(10'd512, 10'd512, 6'd1, BEAR_NORTH, idle_cycles(10));
    send_arc(10'd512, 10'd512, 6'd2, BEAR_EAST, idle_cycles(11));
    send_arc(10'd512, 10'd512, 6'd3, BEAR_SOUTH, idle_cycles(12));
    send_arc(10'd512, 10'd512, 6'd4, BEAR_WEST, idle_cycles(13));
    send_arc(10'h2AA, 10'h155, 6'h2A, BEAR_EAST, idle_cycles(14));
    send_arc(10'h155, 10'h2AA, 6'h15, BEAR_WEST, idle_cycles(15));
    send_arc(10'd0, 10'd1023, 6'd32, BEAR_SOUTH, idle_cycles(16));
    send_arc(10'd1023, 10'd0, 6'd32, BEAR_NORTH, idle_cycles(17));
    send_arc(10'd5, 10'd5, 6'd1, BEAR_WEST, idle_cycles(18));
    send_arc(10'd1020, 10'd3, 6'd7, BEAR_EAST, idle_cycles(19));

    for (int i = 0; i < RANDOM_ARCS; i++) begin
      if ($urandom_range(0, 99) < 70) rad = IN_RW'($urandom_range(0, 20));
      else rad = IN_RW'($urandom_range(0, 63));
      send_arc(IN_CW'($urandom_range(0, 1023)), IN_CW'($urandom_range(0, 1023)),
               rad, bearing_t'($urandom_range(0, 3)), idle_cycles(i));
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d arc commands and %0d point transfers with random gaps,",
             arcs_seen, steps_seen);
    $display("receiver stalls and one %0d-cycle receiver hold with input backpressure.",
             LONG_HOLD);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
